@@ rtl/max_drawdown_tracker_unit_assert.svh @@
// Assertion macros shared by the drawdown tracker RTL
`ifndef MAX_DRAWDOWN_TRACKER_UNIT_ASSERT_SVH
`define MAX_DRAWDOWN_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define MDT_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mdt check failed");

// next-cycle implication
`define MDT_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mdt check failed");

`endif

@@ rtl/mdt_pkg.sv @@
// Package with constants, codes and types of the drawdown tracker
package mdt_pkg;

   localparam int MAX_DAYS_DEF   = 8192;
   localparam int PRICE_BITS_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam int PRICE_W  = 32;
   localparam int OFS_W    = 13;
   localparam int FRAC_W   = 17;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

   localparam logic [OP_W-1:0] OP_OPEN = 2'd0;
   localparam logic [OP_W-1:0] OP_DAY  = 2'd1;
   localparam logic [OP_W-1:0] OP_SKIP = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
      logic                last;
   } item_tag_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
   } div_status_type;

endpackage

@@ rtl/mdt_ifs.sv @@
// Valid/ready channel interfaces for price items and drawdown results
interface mdt_req_if import mdt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] close_price;
   logic               first_of_window;
   logic               last_of_window;

   modport source(output valid, close_price, first_of_window, last_of_window,
                  input ready);
   modport sink(input valid, close_price, first_of_window, last_of_window,
                output ready);
endinterface

interface mdt_rsp_if import mdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAC_W-1:0]   drawdown_fraction;
   logic [OFS_W-1:0]    peak_offset;
   logic [OFS_W-1:0]    trough_offset;
   logic [PRICE_W-1:0]  peak_level;
   logic [PRICE_W-1:0]  trough_level;
   logic                recovered;
   logic [OFS_W-1:0]    recovery_offset;

   modport source(output valid, status, drawdown_fraction, peak_offset, trough_offset,
                  peak_level, trough_level, recovered, recovery_offset,
                  input ready);
   modport sink(input valid, status, drawdown_fraction, peak_offset, trough_offset,
                peak_level, trough_level, recovered, recovery_offset,
                output ready);
endinterface

@@ rtl/mdt_front.sv @@
// Front end: accepts price items, tracks window length and tags each item
module mdt_front import mdt_pkg::*; #(
   parameter int MAX_DAYS   = MAX_DAYS_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF,
   localparam int POS_W     = $clog2(MAX_DAYS + 1),
   localparam int ENTRY_W   = $bits(item_tag_type) + POS_W + PRICE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   mdt_req_if.sink            req_chan,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data
);

   logic [POS_W-1:0] day_ff, day_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] pos;
   item_tag_type     tag;

   always_comb begin
      day_in     = day_ff;
      ovf_in     = ovf_ff;
      pos        = day_ff;
      tag.op     = OP_DAY;
      tag.last   = req_chan.last_of_window;
      tag.status = STATUS_OK;
      if (req_chan.first_of_window || (day_ff == '0)) begin
         tag.op = OP_OPEN;
         day_in = POS_W'(1);
         ovf_in = 1'b0;
         pos    = '0;
      end else if (day_ff >= POS_W'(MAX_DAYS)) begin
         // past the length limit: drop the day, remember it
         tag.op = OP_SKIP;
         ovf_in = 1'b1;
      end else begin
         day_in = day_ff + POS_W'(1);
      end
      if (ovf_in) begin
         tag.status = STATUS_LONG;
      end else if (day_in < POS_W'(2)) begin
         tag.status = STATUS_SHORT;
      end
      if (req_chan.last_of_window) begin
         day_in = '0;
      end
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign q_data         = {tag, pos, PRICE_BITS'(req_chan.close_price)};

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (q_push) begin
         day_ff <= day_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

@@ rtl/mdt_fifo.sv @@
// Short queue between front end and back end
module mdt_fifo import mdt_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + ADDR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + ADDR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign rd_data = mem[rd_ptr_ff];
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/mdt_div.sv @@
// Restoring divider: Q1.16 quotient of drop over peak, one bit per cycle
module mdt_div import mdt_pkg::*; #(
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PRICE_BITS-1:0] dividend,
   input  logic [PRICE_BITS-1:0] divisor,
   output div_status_type        status
);

   localparam int PW     = PRICE_BITS;
   localparam int STEP_W = $clog2(FRAC_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]     rem_ff;
   logic [FRAC_W-1:0] quo_ff;
   logic [PW:0]       trial;
   logic [PW:0]       diff;
   logic              ge;

   // first step takes the integer bit without a shift
   assign trial = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge    = (trial >= {1'b0, divisor});
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == STEP_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? PW'(diff) : PW'(trial);
         quo_ff <= {quo_ff[FRAC_W-2:0], ge};
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

@@ rtl/mdt_back.sv @@
// Back end: running peak, exact drop compare, recovery watch and result register
module mdt_back import mdt_pkg::*; #(
   parameter int MAX_DAYS   = MAX_DAYS_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF,
   localparam int POS_W     = $clog2(MAX_DAYS + 1),
   localparam int ENTRY_W   = $bits(item_tag_type) + POS_W + PRICE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] q_data,
   input  logic               q_empty,
   output logic               q_pop,
   mdt_rsp_if.source          rsp_chan
);

   localparam int PW     = PRICE_BITS;
   localparam int TAG_W  = $bits(item_tag_type);
   localparam int NCH    = (PW + 31) / 32;
   localparam int CW     = (PW + NCH - 1) / NCH;
   localparam int PAD_W  = NCH * CW;
   localparam int NSTEP  = NCH * NCH;
   localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam int IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int ACC_W  = 2 * PAD_W;
   localparam int SH_W   = $clog2(ACC_W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // item under work
   item_tag_type      h_tag, tag_ff;
   logic [POS_W-1:0]  h_pos, pos_ff;
   logic [PW-1:0]     h_close, close_ff;
   logic              take;

   // window state
   logic [PW-1:0]     rp_ff, rp_in;
   logic [POS_W-1:0]  rpp_ff, rpp_in;
   logic [PW-1:0]     bd_ff, bd_in;
   logic [PW-1:0]     bpl_ff, bpl_in;
   logic [PW-1:0]     btl_ff, btl_in;
   logic [POS_W-1:0]  bpp_ff, bpp_in;
   logic [POS_W-1:0]  btp_ff, btp_in;
   logic              rf_ff, rf_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;

   // partial product datapath
   logic [STEP_W-1:0] step_sel;
   logic [IDX_W-1:0]  ci, cj;
   logic [PW-1:0]     close_sel;
   logic [PAD_W-1:0]  rp_pad, btl_pad, close_pad, bpl_pad;
   logic [CW-1:0]     rp_c, btl_c, close_c, bpl_c;
   logic [2*CW-1:0]   pa_ff, pa_in, pb_ff, pb_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [ACC_W-1:0]  acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [ACC_W-1:0]  full_a, full_b;
   logic              issue, clear_acc, accumulate;

   logic              peak_up, better;
   logic              div_start;
   div_status_type    div_stat;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_load, out_free;
   logic [STATUS_W-1:0] o_status;
   logic [FRAC_W-1:0]   o_frac;
   logic [OFS_W-1:0]    o_peak_ofs, o_trough_ofs, o_rec_ofs;
   logic [PRICE_W-1:0]  o_peak, o_trough;
   logic                o_rec;

   assign h_tag   = item_tag_type'(q_data[ENTRY_W-1 -: TAG_W]);
   assign h_pos   = q_data[PW +: POS_W];
   assign h_close = q_data[PW-1:0];

   // operand chunks: rp * btl against close * bpl
   assign step_sel  = (state_ff == S_IDLE) ? '0 : step_ff;
   assign ci        = IDX_W'(step_sel / NCH);
   assign cj        = IDX_W'(step_sel % NCH);
   assign close_sel = (state_ff == S_IDLE) ? h_close : close_ff;
   assign rp_pad    = PAD_W'(rp_ff);
   assign btl_pad   = PAD_W'(btl_ff);
   assign close_pad = PAD_W'(close_sel);
   assign bpl_pad   = PAD_W'(bpl_ff);
   assign rp_c      = rp_pad[ci*CW +: CW];
   assign btl_c     = btl_pad[cj*CW +: CW];
   assign close_c   = close_pad[ci*CW +: CW];
   assign bpl_c     = bpl_pad[cj*CW +: CW];
   assign pa_in     = rp_c * btl_c;
   assign pb_in     = close_c * bpl_c;
   assign sh_in     = SH_W'((ci + cj) * CW);

   assign full_a = acc_a_ff + (ACC_W'(pa_ff) << sh_ff);
   assign full_b = acc_b_ff + (ACC_W'(pb_ff) << sh_ff);

   always_comb begin
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      if (clear_acc) begin
         acc_a_in = '0;
         acc_b_in = '0;
      end else if (accumulate) begin
         acc_a_in = full_a;
         acc_b_in = full_b;
      end
   end

   // a drop beats the best when rp * btl > close * bpl; a rising close never does
   assign peak_up = (close_ff > rp_ff);
   assign better  = (rp_ff != '0) && (close_ff < rp_ff) &&
                    ((bd_ff == '0) || (full_a > full_b));

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      take       = 1'b0;
      issue      = 1'b0;
      clear_acc  = 1'b0;
      accumulate = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      rp_in      = rp_ff;
      rpp_in     = rpp_ff;
      bd_in      = bd_ff;
      bpl_in     = bpl_ff;
      btl_in     = btl_ff;
      bpp_in     = bpp_ff;
      btp_in     = btp_ff;
      rf_in      = rf_ff;
      rpos_in    = rpos_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               take = 1'b1;
               case (h_tag.op)
                  OP_OPEN: begin
                     rp_in   = h_close;
                     rpp_in  = '0;
                     bd_in   = '0;
                     bpl_in  = h_close;
                     btl_in  = h_close;
                     bpp_in  = '0;
                     btp_in  = '0;
                     rf_in   = 1'b0;
                     rpos_in = '0;
                     if (h_tag.last) begin
                        state_in = S_OUT;
                     end
                  end
                  OP_DAY: begin
                     issue     = 1'b1;
                     clear_acc = 1'b1;
                     step_in   = STEP_W'(1);
                     state_in  = (NSTEP > 1) ? S_MUL : S_CMP;
                  end
                  default: begin
                     if (h_tag.last) begin
                        state_in = S_OUT;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            issue      = 1'b1;
            accumulate = 1'b1;
            if (step_ff == STEP_W'(NSTEP - 1)) begin
               state_in = S_CMP;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_CMP: begin
            if (peak_up) begin
               rp_in  = close_ff;
               rpp_in = pos_ff;
            end
            if (better) begin
               bd_in   = rp_ff - close_ff;
               bpl_in  = rp_ff;
               btl_in  = close_ff;
               bpp_in  = rpp_ff;
               btp_in  = pos_ff;
               rf_in   = 1'b0;
               rpos_in = '0;
            end else if (!rf_ff && (pos_ff > btp_ff) && (close_ff >= bpl_ff)) begin
               rf_in   = 1'b1;
               rpos_in = pos_ff;
            end
            if (!tag_ff.last) begin
               state_in = S_IDLE;
            end else if ((tag_ff.status == STATUS_OK) && (bd_in != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign q_pop = take;

   mdt_div #(
      .PRICE_BITS(PRICE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(bd_in),
      .divisor (bpl_ff),
      .status  (div_stat)
   );

   always_comb begin
      o_status     = tag_ff.status;
      o_frac       = '0;
      o_peak_ofs   = '0;
      o_trough_ofs = '0;
      o_peak       = '0;
      o_trough     = '0;
      o_rec        = 1'b0;
      o_rec_ofs    = '0;
      if (tag_ff.status == STATUS_OK) begin
         o_frac       = (bd_ff != '0) ? div_stat.quotient : '0;
         o_peak_ofs   = OFS_W'(bpp_ff);
         o_trough_ofs = OFS_W'(btp_ff);
         o_peak       = PRICE_W'(bpl_ff);
         o_trough     = PRICE_W'(btl_ff);
         o_rec        = rf_ff;
         o_rec_ofs    = rf_ff ? OFS_W'(rpos_ff) : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tag_ff   <= h_tag;
         pos_ff   <= h_pos;
         close_ff <= h_close;
      end
      if (issue) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         sh_ff <= sh_in;
      end
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      rp_ff    <= rp_in;
      rpp_ff   <= rpp_in;
      bd_ff    <= bd_in;
      bpl_ff   <= bpl_in;
      btl_ff   <= btl_in;
      bpp_ff   <= bpp_in;
      btp_ff   <= btp_in;
      rf_ff    <= rf_in;
      rpos_ff  <= rpos_in;
      if (out_load) begin
         rsp_chan.status            <= o_status;
         rsp_chan.drawdown_fraction <= o_frac;
         rsp_chan.peak_offset       <= o_peak_ofs;
         rsp_chan.trough_offset     <= o_trough_ofs;
         rsp_chan.peak_level        <= o_peak;
         rsp_chan.trough_level      <= o_trough;
         rsp_chan.recovered         <= o_rec;
         rsp_chan.recovery_offset   <= o_rec_ofs;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

@@ rtl/max_drawdown_tracker_unit.sv @@
// Top level of the maximum drawdown tracker: front end, item queue, back end
// The back end works on one queued item at a time. A day item runs the partial products of
// NCH*NCH chunk pairs, NCH = ceil(PRICE_BITS/32), and then the compare; open and over-length
// items need no compare, and a one-day window goes straight to the result register. A last
// day runs the compare, the divider if there is a drop, then waits for the result register.
// Reset is synchronous: clears window count, queue pointers and result valid.
`include "max_drawdown_tracker_unit_assert.svh"

module max_drawdown_tracker_unit import mdt_pkg::*; #(
   parameter int MAX_DAYS   = MAX_DAYS_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mdt_req_if.sink   req_chan,
   mdt_rsp_if.source rsp_chan
);

   localparam int POS_W   = $clog2(MAX_DAYS + 1);
   localparam int ENTRY_W = $bits(item_tag_type) + POS_W + PRICE_BITS;

   logic               q_push, q_pop, q_full, q_empty;
   logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

   mdt_front #(
      .MAX_DAYS  (MAX_DAYS),
      .PRICE_BITS(PRICE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_wr_data)
   );

   mdt_fifo #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_data(q_wr_data),
      .pop    (q_pop),
      .rd_data(q_rd_data),
      .full   (q_full),
      .empty  (q_empty)
   );

   mdt_back #(
      .MAX_DAYS  (MAX_DAYS),
      .PRICE_BITS(PRICE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_rd_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_chan(rsp_chan)
   );

   `MDT_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_full, !q_push)
   `MDT_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, q_pop, !q_empty)
   `MDT_ASSERT_NEXT(a_push_fills_queue, clock, reset, q_push && !q_pop, !q_empty)

endmodule

@@ tb/max_drawdown_tracker_checker.sv @@
// Checker for the drawdown tracker: predicts each window summary and compares the results
`timescale 1ns / 1ps

module max_drawdown_tracker_checker import mdt_pkg::*; #(
   parameter int MAX_DAYS = MAX_DAYS_DEF
) (
   input  logic clock,
   input  logic reset,
   mdt_req_if   req_mon,
   mdt_rsp_if   rsp_mon,
   output int   mismatches,
   output int   summaries_due,
   output int   summaries_checked
);

   localparam int REPORT_CAP = 40;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [FRAC_W-1:0]   fraction;
      logic [OFS_W-1:0]    peak_ofs;
      logic [OFS_W-1:0]    trough_ofs;
      logic [PRICE_W-1:0]  peak_lvl;
      logic [PRICE_W-1:0]  trough_lvl;
      logic                regained;
      logic [OFS_W-1:0]    regain_ofs;
   } drawdown_summary_type;

   drawdown_summary_type summary_due[$];

   // window state of the predictor
   int unsigned        day_count;
   bit                 overflowed;
   logic [PRICE_W-1:0] peak_now;
   int unsigned        peak_at;
   logic [PRICE_W-1:0] best_drop;
   logic [PRICE_W-1:0] best_peak;
   int unsigned        best_peak_at;
   int unsigned        best_trough_at;
   bit                 regained;
   int unsigned        regained_at;

   task automatic track_close_price(input logic [PRICE_W-1:0] close, input logic first,
                                    input logic last);
      drawdown_summary_type want;
      bit                   better;
      logic [PRICE_W-1:0]   drop;
      logic [63:0]          lhs;
      logic [63:0]          rhs;
      logic [63:0]          ratio;
      better = 1'b0;
      if (first || day_count == 0) begin
         // open a new window with this item at offset zero
         day_count      = 1;
         overflowed     = 1'b0;
         peak_now       = close;
         peak_at        = 0;
         best_drop      = '0;
         best_peak      = close;
         best_peak_at   = 0;
         best_trough_at = 0;
         regained       = 1'b0;
         regained_at    = 0;
      end else if (day_count >= MAX_DAYS) begin
         overflowed = 1'b1;
      end else begin
         if (close > peak_now) begin
            peak_now = close;
            peak_at  = day_count;
         end
         // a zero peak never evaluates a drop
         if (peak_now != 0) begin
            drop = peak_now - close;
            if (best_drop == 0) begin
               better = (drop != 0);
            end else begin
               lhs    = {32'b0, drop} * {32'b0, best_peak};
               rhs    = {32'b0, best_drop} * {32'b0, peak_now};
               better = (lhs > rhs);
            end
            if (better) begin
               best_drop      = drop;
               best_peak      = peak_now;
               best_peak_at   = peak_at;
               best_trough_at = day_count;
               regained       = 1'b0;
               regained_at    = 0;
            end
         end
         if (!better && !regained && day_count > best_trough_at && close >= best_peak) begin
            regained    = 1'b1;
            regained_at = day_count;
         end
         day_count++;
      end

      if (last) begin
         want = '{status: STATUS_OK, fraction: '0, peak_ofs: '0, trough_ofs: '0,
                  peak_lvl: '0, trough_lvl: '0, regained: 1'b0, regain_ofs: '0};
         if (overflowed) begin
            want.status = STATUS_LONG;
         end else if (day_count < 2) begin
            want.status = STATUS_SHORT;
         end else begin
            ratio = '0;
            if (best_drop != 0 && best_peak != 0)
               ratio = {16'b0, best_drop, 16'b0} / {32'b0, best_peak};
            want.fraction   = ratio[FRAC_W-1:0];
            want.peak_ofs   = best_peak_at[OFS_W-1:0];
            want.trough_ofs = best_trough_at[OFS_W-1:0];
            want.peak_lvl   = best_peak;
            want.trough_lvl = best_peak - best_drop;
            want.regained   = regained;
            want.regain_ofs = regained ? regained_at[OFS_W-1:0] : '0;
         end
         summary_due.insert(summary_due.size(), want);
         day_count = 0;
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, what, want, want, got, got);
      end
   endtask

   always @(posedge clock) begin
      drawdown_summary_type want;
      if (reset) begin
         day_count         = 0;
         overflowed        = 1'b0;
         peak_now          = '0;
         peak_at           = 0;
         best_drop         = '0;
         best_peak         = '0;
         best_peak_at      = 0;
         best_trough_at    = 0;
         regained          = 1'b0;
         regained_at       = 0;
         mismatches        = 0;
         summaries_checked = 0;
         summary_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            track_close_price(req_mon.close_price, req_mon.first_of_window,
                              req_mon.last_of_window);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (summary_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t ns: unexpected result item, expected nothing, actual status %0d",
                           $time, rsp_mon.status);
            end else begin
               want = summary_due.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("drawdown_fraction", want.fraction, rsp_mon.drawdown_fraction);
               check_field("peak_offset", want.peak_ofs, rsp_mon.peak_offset);
               check_field("trough_offset", want.trough_ofs, rsp_mon.trough_offset);
               check_field("peak_level", want.peak_lvl, rsp_mon.peak_level);
               check_field("trough_level", want.trough_lvl, rsp_mon.trough_level);
               check_field("recovered", want.regained, rsp_mon.recovered);
               check_field("recovery_offset", want.regain_ofs, rsp_mon.recovery_offset);
               summaries_checked++;
            end
         end
      end
      summaries_due = summary_due.size();
   end

endmodule

@@ tb/max_drawdown_tracker_unit_test.sv @@
// Top of the drawdown tracker testbench: clock, reset, price stimulus, stalls and verdict
`timescale 1ns / 1ps

module max_drawdown_tracker_unit_test;
   import mdt_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 40;

   typedef enum {PRICE_ANY, PRICE_WALK, PRICE_SMALL, PRICE_HIGH, PRICE_BIT} price_mode_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic clock;
   logic reset;

   mdt_req_if req_chan();
   mdt_rsp_if rsp_chan();

   int mismatches;
   int summaries_due;
   int summaries_checked;

   int items_sent;
   int windows_closed;
   int burst_left;
   int idle_cycles;

   ready_mode_type ready_mode;
   int             ready_left;
   int             ready_tick;

   max_drawdown_tracker_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   max_drawdown_tracker_checker #(.MAX_DAYS(MAX_DAYS_DEF)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatches       (mismatches),
      .summaries_due    (summaries_due),
      .summaries_checked(summaries_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [PRICE_W-1:0] next_close(input price_mode_type mode,
                                                     input logic [PRICE_W-1:0] prev);
      longint v;
      longint span;
      case (mode)
         PRICE_WALK: begin
            // mostly small moves, now and then a swing of up to a quarter of the level
            span = ($urandom_range(0, 3) == 0) ? longint'({32'b0, prev >> 2}) : 1000;
            if (span < 1000) span = 1000;
            v = longint'({32'b0, prev}) + longint'($urandom_range(0, 2 * span)) - span;
            if (v < 0) v = 0;
            if (v > 64'sh0000_0000_FFFF_FFFF) v = 64'sh0000_0000_FFFF_FFFF;
            return v[PRICE_W-1:0];
         end
         PRICE_SMALL: return $urandom_range(0, 12);
         PRICE_HIGH:  return 32'hFFFF_FFFF - $urandom_range(0, 40);
         PRICE_BIT:   return ($urandom_range(0, 4) == 0) ? '0 : 32'h1 << $urandom_range(0, 31);
         default:     return $urandom;
      endcase
   endfunction

   task automatic send_close(input logic [PRICE_W-1:0] price, input logic first,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid           <= 1'b1;
      req_chan.close_price     <= price;
      req_chan.first_of_window <= first;
      req_chan.last_of_window  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (last) windows_closed++;
   endtask

   // send a window; restart_at marks an offset that reopens it mid-way
   task automatic send_window(input int len, input price_mode_type mode, input bit lead_first,
                              input int restart_at);
      logic [PRICE_W-1:0] price;
      price = $urandom >> $urandom_range(0, 31);
      for (int i = 0; i < len; i++) begin
         if (i > 0 || mode != PRICE_WALK) price = next_close(mode, price);
         send_close(price, (i == 0 && lead_first) || i == restart_at, i == len - 1);
      end
   endtask

   // receiver stalls in stretches: always ready, coin flips, or rare ready
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(10, 150);
      end
      ready_left--;
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS: rsp_chan.ready <= 1'b1;
         READY_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
         default:      rsp_chan.ready <= (ready_tick % 7 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int             mark;
      int             pick;
      int             len;
      price_mode_type mode;
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.close_price     = '0;
      req_chan.first_of_window = 1'b0;
      req_chan.last_of_window  = 1'b0;
      rsp_chan.ready           = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no window open after reset: the first item opens one; full drop to zero
      send_close(32'h8000_0000, 1'b0, 1'b0);
      send_close(32'h0000_0000, 1'b0, 1'b1);
      // one-day windows, with and without the first mark
      send_close(32'd12345, 1'b1, 1'b1);
      send_close(32'd7, 1'b0, 1'b1);
      // rising prices: no drop, recovery of the first close
      send_close(32'd100, 1'b1, 1'b0);
      send_close(32'd200, 1'b0, 1'b0);
      send_close(32'd300, 1'b0, 1'b1);
      // zero running peak holds off drop evaluation
      send_close(32'd0, 1'b1, 1'b0);
      send_close(32'd0, 1'b0, 1'b0);
      send_close(32'd5, 1'b0, 1'b0);
      send_close(32'd3, 1'b0, 1'b1);
      // price extremes with a regained peak
      send_close(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_close(32'd1, 1'b0, 1'b0);
      send_close(32'hFFFF_FFFF, 1'b0, 1'b1);
      // equal fractional drop keeps the earlier pair
      send_close(32'd10, 1'b1, 1'b0);
      send_close(32'd5, 1'b0, 1'b0);
      send_close(32'd20, 1'b0, 1'b0);
      send_close(32'd10, 1'b0, 1'b0);
      send_close(32'd20, 1'b0, 1'b1);
      // restart drops the open window
      send_close(32'd50, 1'b1, 1'b0);
      send_close(32'd40, 1'b0, 1'b0);
      send_close(32'd100, 1'b1, 1'b0);
      send_close(32'd90, 1'b0, 1'b0);
      send_close(32'd95, 1'b0, 1'b1);

      mark = items_sent;
      while (items_sent < mark + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         mode = ($urandom_range(0, 1) == 1) ? PRICE_WALK
                                            : price_mode_type'($urandom_range(0, 4));
         if (pick < 80) begin
            pick = $urandom_range(0, 99);
            len  = (pick < 8) ? 1 : (pick < 90) ? $urandom_range(2, 24) : $urandom_range(25, 200);
            send_window(len, mode, 1'b1, -1);
         end else if (pick < 90) begin
            len = $urandom_range(3, 30);
            send_window(len, mode, 1'($urandom_range(0, 1)), $urandom_range(1, len - 1));
         end else begin
            repeat ($urandom_range(1, 6))
               send_close($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (summaries_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d price items in %0d closed windows: corner cases,",
               items_sent, windows_closed);
      $display("random walks, ties, restarts and noise; %0d results compared",
               summaries_checked);
      if (mismatches == 0 && summaries_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mdt_pkg.sv
rtl/mdt_ifs.sv
rtl/mdt_front.sv
rtl/mdt_fifo.sv
rtl/mdt_div.sv
rtl/mdt_back.sv
rtl/max_drawdown_tracker_unit.sv
tb/max_drawdown_tracker_checker.sv
tb/max_drawdown_tracker_unit_test.sv
